// ===== src/fl16_pkg.sv =====
// fl16_pkg: shared types, constants and mod-255 helpers for the fletcher-16 block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fl16_pkg;

  localparam int unsigned MaxLen   = 65535;
  localparam int unsigned Mod      = 255;
  localparam int unsigned ModBias  = 65535;  // 255*257, keeps length minus offset nonnegative
  localparam int unsigned QDepth   = 2;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [15:0] check_offset;
  } in_word_t;

  typedef struct packed {
    logic [15:0] checksum;
    logic [7:0]  check_x;
    logic [7:0]  check_y;
    logic        insert_mode;
    logic        too_long;
  } out_word_t;

  // finished sums of one message, handed from front to back
  typedef struct packed {
    logic [7:0]  sum0;
    logic [7:0]  sum1;
    logic [15:0] len;
    logic [15:0] offset;
    logic        overflow;
  } msg_rec_t;

  // (a + b) mod 255 for a in 0..254, b in 0..255
  function automatic logic [7:0] add_mod255(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 9'(Mod)) s = s - 9'(Mod);
    return s[7:0];
  endfunction

  // v mod 255 for a 17-bit value
  function automatic logic [7:0] mod255_17(input logic [16:0] v);
    logic [9:0] a;
    logic [8:0] b;
    a = {1'b0, v[16:8]} + {2'b00, v[7:0]};
    b = {7'b0, a[9:8]} + {1'b0, a[7:0]};
    if (b >= 9'(Mod)) b = b - 9'(Mod);
    return b[7:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/fl16_front.sv =====
// fl16_front: per-byte accumulation of both fletcher sums, count and offset
// depends on fl16_pkg; pushes one msg_rec_t per message into the queue
`timescale 1ns / 1ps
`default_nettype none

module fl16_front import fl16_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     accept_i,
  input  wire in_word_t word_i,
  output logic          rec_push_o,
  output msg_rec_t      rec_o
);

  logic [7:0]  sum0_q, sum0_d, sum1_q, sum1_d;
  logic [15:0] cnt_q, cnt_d, off_q, off_d;
  logic        ovf_q, ovf_d;

  logic [15:0] off_use, cnt_nx;
  logic        ovf_nx, pos_known, zero_byte;
  logic [7:0]  b, s0_nx, s1_nx;

  always_comb begin
    off_use   = (cnt_q == '0 && !ovf_q) ? word_i.check_offset : off_q;
    pos_known = !ovf_q && (cnt_q < 16'(MaxLen));
    cnt_nx    = pos_known ? cnt_q + 16'd1 : cnt_q;
    ovf_nx    = ovf_q || !pos_known;
    zero_byte = pos_known && (off_use != '0) &&
                ((cnt_q == off_use - 16'd1) || (cnt_q == off_use));
    b         = zero_byte ? 8'd0 : word_i.data_byte;
    s0_nx     = add_mod255(sum0_q, b);
    s1_nx     = add_mod255(sum1_q, s0_nx);
  end

  always_comb begin
    sum0_d = sum0_q;
    sum1_d = sum1_q;
    cnt_d  = cnt_q;
    off_d  = off_q;
    ovf_d  = ovf_q;
    if (accept_i) begin
      if (word_i.last_byte) begin
        sum0_d = '0;
        sum1_d = '0;
        cnt_d  = '0;
        off_d  = '0;
        ovf_d  = 1'b0;
      end else begin
        sum0_d = s0_nx;
        sum1_d = s1_nx;
        cnt_d  = cnt_nx;
        off_d  = off_use;
        ovf_d  = ovf_nx;
      end
    end
  end

  assign rec_push_o    = accept_i && word_i.last_byte;
  assign rec_o.sum0     = s0_nx;
  assign rec_o.sum1     = s1_nx;
  assign rec_o.len      = cnt_nx;
  assign rec_o.offset   = off_use;
  assign rec_o.overflow = ovf_nx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum0_q <= '0;
      sum1_q <= '0;
      cnt_q  <= '0;
      off_q  <= '0;
      ovf_q  <= 1'b0;
    end else begin
      sum0_q <= sum0_d;
      sum1_q <= sum1_d;
      cnt_q  <= cnt_d;
      off_q  <= off_d;
      ovf_q  <= ovf_d;
    end
  end

  // message end clears the running state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_push_o |=> (cnt_q == '0 && !ovf_q && sum0_q == '0 && sum1_q == '0))
    else $error("front state not cleared after last word");

endmodule

`default_nettype wire

// ===== src/fl16_queue.sv =====
// fl16_queue: short register queue of message records between front and back
// depends on fl16_pkg
`timescale 1ns / 1ps
`default_nettype none

module fl16_queue import fl16_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire msg_rec_t rec_i,
  output logic          full_o,
  input  wire logic     pop_i,
  output logic          valid_o,
  output msg_rec_t      rec_o
);

  msg_rec_t           mem_q [QDepth];
  logic [QPtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [QCntW-1:0]   cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign rec_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [QPtrW-1:0] ptr_inc(input logic [QPtrW-1:0] p);
    return (p == QPtrW'(QDepth - 1)) ? '0 : p + QPtrW'(1);
  endfunction

  always_comb begin
    wr_d  = do_push ? ptr_inc(wr_q) : wr_q;
    rd_d  = do_pop ? ptr_inc(rd_q) : rd_q;
    cnt_d = cnt_q + QCntW'(do_push) - QCntW'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= rec_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= QCntW'(QDepth))
    else $error("queue count beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push_i && full_o))
    else $error("record pushed into full queue");

endmodule

`default_nettype wire

// ===== src/fl16_back.sv =====
// fl16_back: three-stage finisher, computes check bytes and holds the result word
// depends on fl16_pkg; stage 1 length mod 255, stage 2 multiply, stage 3 x and y
`timescale 1ns / 1ps
`default_nettype none

module fl16_back import fl16_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     rec_valid_i,
  input  wire msg_rec_t rec_i,
  output logic          rec_pop_o,
  output logic          out_valid_o,
  output out_word_t     out_word_o,
  input  wire logic     pop_i
);

  logic      s1_v_q, s2_v_q, o_v_q;
  msg_rec_t  s1_rec_q, s2_rec_q;
  logic [7:0]  s1_d_q, s1_d_d;
  logic [15:0] s2_p_q, s2_p_d;
  out_word_t o_word_q, o_word_d;
  logic      s1_adv, s2_adv, o_adv;

  logic [16:0] diff, tsum;
  logic [7:0]  t, x;
  logic [8:0]  y;
  logic        ins;

  assign o_adv     = !o_v_q || pop_i;
  assign s2_adv    = !s2_v_q || o_adv;
  assign s1_adv    = !s1_v_q || s2_adv;
  assign rec_pop_o = rec_valid_i && s1_adv;

  always_comb begin
    diff   = 17'(rec_i.len) + 17'(ModBias) - 17'(rec_i.offset);
    s1_d_d = mod255_17(diff);
    s2_p_d = 16'(s1_d_q) * 16'(s1_rec_q.sum0);
  end

  always_comb begin
    ins  = (s2_rec_q.offset != '0);
    tsum = 17'(s2_p_q) + 17'(Mod) - 17'(s2_rec_q.sum1);
    t    = mod255_17(tsum);
    x    = (t == '0) ? 8'(Mod) : t;
    y    = 9'(2 * Mod) - 9'(s2_rec_q.sum0) - 9'(x);
    if (y > 9'(Mod)) y = y - 9'(Mod);
    o_word_d.checksum    = {s2_rec_q.sum1, s2_rec_q.sum0};
    o_word_d.check_x     = ins ? x : 8'd0;
    o_word_d.check_y     = ins ? y[7:0] : 8'd0;
    o_word_d.insert_mode = ins;
    o_word_d.too_long    = s2_rec_q.overflow;
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s1_rec_q <= rec_i;
      s1_d_q   <= s1_d_d;
    end
    if (s2_adv) begin
      s2_rec_q <= s1_rec_q;
      s2_p_q   <= s2_p_d;
    end
    if (o_adv) o_word_q <= o_word_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      o_v_q  <= 1'b0;
    end else begin
      if (s1_adv) s1_v_q <= rec_valid_i;
      if (s2_adv) s2_v_q <= s1_v_q;
      if (o_adv)  o_v_q  <= s2_v_q;
    end
  end

  assign out_valid_o = o_v_q;
  assign out_word_o  = o_word_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_v_q && !o_word_q.insert_mode) |-> (o_word_q.check_x == '0 && o_word_q.check_y == '0))
    else $error("check bytes nonzero outside insert mode");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_v_q && o_word_q.insert_mode) |-> (o_word_q.check_x != '0 && o_word_q.check_y != '0))
    else $error("check byte zero in insert mode");

endmodule

`default_nettype wire

// ===== src/fletcher16_iso_checksum.sv =====
// fletcher16_iso_checksum: top level, front accumulator, record queue, back finisher
// depends on fl16_pkg, fl16_front, fl16_queue, fl16_back
//
//   channel  | handshake                 | word
//   ---------+---------------------------+------------------------------------
//   input    | push_i / full             | in_word_i  (data, last, offset)
//   result   | empty / pop_i             | out_word_o (checksum, x, y, flags)
//
// one input word per cycle while full is low; the front updates both sums in the cycle a word is taken
// a result passes from the record queue through the finisher stages to out_word_o, one per cycle at most
// full rises only when the two-entry record queue and the finisher stages are all held
// by a stalled pop_i; reset clears sums, count, queue and pipeline valids at once
`timescale 1ns / 1ps
`default_nettype none

module fletcher16_iso_checksum import fl16_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  output logic          full,
  input  wire in_word_t in_word_i,
  output logic          empty,
  input  wire logic     pop_i,
  output out_word_t     out_word_o
);

  logic     accept, rec_push, q_full, q_valid, q_pop, out_valid;
  msg_rec_t rec_in, rec_out;

  assign full   = q_full;
  assign accept = push_i && !q_full;
  assign empty  = !out_valid;

  fl16_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .word_i     (in_word_i),
    .rec_push_o (rec_push),
    .rec_o      (rec_in)
  );

  fl16_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_push),
    .rec_i   (rec_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rec_o   (rec_out)
  );

  fl16_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (q_valid),
    .rec_i       (rec_out),
    .rec_pop_o   (q_pop),
    .out_valid_o (out_valid),
    .out_word_o  (out_word_o),
    .pop_i       (pop_i)
  );

endmodule

`default_nettype wire

// ===== bench/tb_fletcher16_iso_checksum.sv =====
// tb_fletcher16_iso_checksum: self-checking bench for the fletcher-16 checksum block
// depends on fl16_pkg and fletcher16_iso_checksum; a directed table, then random messages
// results are predicted in-bench or taken from the table, and compared word by word in arrival order
`timescale 1ns / 1ps

module tb_fletcher16_iso_checksum;
  import fl16_pkg::*;

  localparam int unsigned CycLimit = 1000000;
  localparam int unsigned DirRows  = 19;

  typedef struct {
    logic [7:0]  data;
    logic        last;
    logic [15:0] offs;
    bit          typed;
    out_word_t   want;
  } dir_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      push_i;
  logic      full;
  in_word_t  in_word_i;
  logic      empty;
  logic      pop_i;
  out_word_t out_word_o;

  // running sums and message state of the predictor
  int unsigned acc_lo;
  int unsigned acc_hi;
  int unsigned msg_len;
  int unsigned fld_pos;
  logic        len_ovf;

  out_word_t   sums_due[$];
  int unsigned err_cnt;
  int unsigned cyc_cnt;
  int unsigned send_idle;
  int unsigned stall_pct;

  dir_row_t dir_tab [0:DirRows-1] = '{
    '{8'h00, 1'b1, 16'h0000, 1'b1, '{16'h0000, 8'h00, 8'h00, 1'b0, 1'b0}},
    '{8'hFF, 1'b1, 16'h0000, 1'b1, '{16'h0000, 8'h00, 8'h00, 1'b0, 1'b0}},
    '{8'hFE, 1'b1, 16'h0000, 1'b1, '{16'hFEFE, 8'h00, 8'h00, 1'b0, 1'b0}},
    '{8'hAB, 1'b1, 16'h0001, 1'b1, '{16'h0000, 8'hFF, 8'hFF, 1'b1, 1'b0}},
    '{8'h80, 1'b1, 16'hFFFF, 1'b1, '{16'h8080, 8'hFF, 8'h7F, 1'b1, 1'b0}},
    // offset of one zeroes the first two bytes
    '{8'h12, 1'b0, 16'h0001, 1'b0, '0},
    '{8'h34, 1'b1, 16'h0000, 1'b0, '0},
    // check field in the middle
    '{8'h01, 1'b0, 16'h0002, 1'b0, '0},
    '{8'h02, 1'b0, 16'h0000, 1'b0, '0},
    '{8'h03, 1'b0, 16'h0000, 1'b0, '0},
    '{8'h04, 1'b1, 16'h0000, 1'b0, '0},
    // check field runs past the end, later offsets ignored
    '{8'hFF, 1'b0, 16'h0003, 1'b0, '0},
    '{8'hFF, 1'b0, 16'hFFFF, 1'b0, '0},
    '{8'hFF, 1'b1, 16'h5555, 1'b0, '0},
    // offset far past the end
    '{8'h5A, 1'b0, 16'h0064, 1'b0, '0},
    '{8'hA5, 1'b1, 16'h0000, 1'b0, '0},
    // verify only
    '{8'h00, 1'b0, 16'h0000, 1'b0, '0},
    '{8'hFF, 1'b0, 16'hAAAA, 1'b0, '0},
    '{8'h7F, 1'b1, 16'hFFFF, 1'b0, '0}
  };

  fletcher16_iso_checksum u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push_i),
    .full      (full),
    .in_word_i (in_word_i),
    .empty     (empty),
    .pop_i     (pop_i),
    .out_word_o(out_word_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic fletcher_step(input in_word_t w, output logic made, output out_word_t res);
    int unsigned b;
    int unsigned pos;
    int unsigned d;
    int unsigned t;
    int unsigned x;
    int unsigned y;
    logic        known;
    made = 1'b0;
    res  = '0;
    b    = w.data_byte;
    if (msg_len == 0 && !len_ovf) fld_pos = w.check_offset;
    pos   = msg_len;
    known = !len_ovf && msg_len < MaxLen;
    if (known) msg_len++;
    else len_ovf = 1'b1;
    if (known && fld_pos != 0 && (pos == fld_pos - 1 || pos == fld_pos)) b = 0;
    acc_lo = (acc_lo + b) % Mod;
    acc_hi = (acc_hi + acc_lo) % Mod;
    if (w.last_byte) begin
      made         = 1'b1;
      res.checksum = {acc_hi[7:0], acc_lo[7:0]};
      if (fld_pos != 0) begin
        // length minus offset, kept nonnegative by a multiple of 255
        d = (msg_len + 65535 - fld_pos) % Mod;
        t = (d * acc_lo + Mod - acc_hi) % Mod;
        x = (t == 0) ? Mod : t;
        y = 2 * Mod - acc_lo - x;
        if (y > Mod) y = y - Mod;
        res.check_x = x[7:0];
        res.check_y = y[7:0];
      end
      res.insert_mode = (fld_pos != 0);
      res.too_long    = len_ovf;
      acc_lo  = 0;
      acc_hi  = 0;
      msg_len = 0;
      fld_pos = 0;
      len_ovf = 1'b0;
    end
  endtask

  // called at a falling edge, returns at the falling edge after the word is taken
  task automatic push_word(input in_word_t w, output logic made, output out_word_t pred);
    while ($urandom_range(99) < send_idle) begin
      push_i    = 1'b0;
      in_word_i = in_word_t'($urandom);
      @(negedge clk_i);
    end
    push_i    = 1'b1;
    in_word_i = w;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    fletcher_step(w, made, pred);
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(9) == 0) return $urandom_range(1) ? 8'hFF : 8'h00;
    return 8'($urandom_range(255));
  endfunction

  task automatic send_message(input int unsigned len, input logic [15:0] offs);
    in_word_t  w;
    logic      made;
    out_word_t pred;
    for (int unsigned k = 0; k < len; k++) begin
      w.data_byte    = pick_byte();
      w.last_byte    = (k == len - 1);
      w.check_offset = (k == 0) ? offs : 16'($urandom);
      push_word(w, made, pred);
      if (made) sums_due.push_back(pred);
    end
  endtask

  task automatic run_messages(input int unsigned n_words);
    int unsigned sent;
    int unsigned len;
    int unsigned r;
    logic [15:0] offs;
    sent = 0;
    while (sent < n_words) begin
      len = ($urandom_range(3) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
      r   = $urandom_range(99);
      if (r < 15) offs = 16'h0000;
      else if (r < 30) offs = 16'($urandom_range(65535));
      else offs = 16'($urandom_range(len + 1, 1));
      send_message(len, offs);
      sent += len;
    end
  endtask

  task automatic check_word(input out_word_t got);
    out_word_t want;
    if (sums_due.size() == 0) begin
      $error("unexpected result word %h", got);
      err_cnt++;
    end else begin
      want = sums_due.pop_front();
      if (got.checksum !== want.checksum) begin
        $error("checksum: expected %h, got %h", want.checksum, got.checksum);
        err_cnt++;
      end
      if (got.check_x !== want.check_x) begin
        $error("check_x: expected %h, got %h", want.check_x, got.check_x);
        err_cnt++;
      end
      if (got.check_y !== want.check_y) begin
        $error("check_y: expected %h, got %h", want.check_y, got.check_y);
        err_cnt++;
      end
      if (got.insert_mode !== want.insert_mode) begin
        $error("insert_mode: expected %b, got %b", want.insert_mode, got.insert_mode);
        err_cnt++;
      end
      if (got.too_long !== want.too_long) begin
        $error("too_long: expected %b, got %b", want.too_long, got.too_long);
        err_cnt++;
      end
    end
  endtask

  initial begin
    pop_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      pop_i = ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop_i && !empty) check_word(out_word_o);
  end

  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt > CycLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    in_word_t  w;
    logic      made;
    out_word_t pred;
    rst_ni    = 1'b0;
    push_i    = 1'b0;
    in_word_i = '0;
    err_cnt   = 0;
    cyc_cnt   = 0;
    acc_lo    = 0;
    acc_hi    = 0;
    msg_len   = 0;
    fld_pos   = 0;
    len_ovf   = 1'b0;
    send_idle = 16;
    stall_pct = 61;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < DirRows; i++) begin
      w = '{dir_tab[i].data, dir_tab[i].last, dir_tab[i].offs};
      push_word(w, made, pred);
      if (dir_tab[i].typed) sums_due.push_back(dir_tab[i].want);
      else if (made) sums_due.push_back(pred);
    end
    run_messages(170);

    send_idle = 61;
    stall_pct = 16;
    run_messages(170);

    send_idle = 0;
    stall_pct = 0;
    run_messages(170);
    push_i = 1'b0;

    while (sums_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
